### src/cpa_pkg.sv
// Shared constants and codes for the contiguous page allocator.
// No dependencies; imported by the core and its checker.
package cpa_pkg;

    localparam int NUM_PAGES  = 256;
    localparam int PAGE_SHIFT = 12;                  // 4096-byte pages
    localparam int IDX_W      = $clog2(NUM_PAGES);   // 8
    localparam int COUNT_W    = IDX_W + 1;           // 9, holds NUM_PAGES
    localparam int PID_W      = 8;
    localparam int BYTES_W    = 21;
    localparam int PAGES_W    = BYTES_W - PAGE_SHIFT + 1;

    typedef enum logic [1:0] {
        ST_ALLOC    = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_RELEASED = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NONE  = 2'd3
    } fit_t;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

endpackage

### src/contiguous_page_allocator_core.sv
// Contiguous page allocator, microcoded: owner table plus control ROM.
// Depends on cpa_pkg.
//
// Input channel (in_valid/in_ready) takes one word: kind, process_id,
// request_bytes, fit_mode. Output channel (out_valid/out_ready) returns one
// word per input: status, start_page, page_count.
// A small control ROM steps a datapath over a 256-entry owner memory with a
// registered read port; one entry is read or written per cycle.
// Allocate: setup latches the word, dispatches it and starts the scan; the
// scan visits all 256 entries, a close step ends the last run, the pages are
// written in turn, the result is posted; a bad id, mode or size is refused
// after setup, a request with no hole after the scan. Release: setup, a scan
// up to and including the first entry past the process's first run, then the result.
// in_ready is high only while the sequencer waits at its idle step.
// The result sits in an output register, so a new word is taken while the
// previous result waits; the sequencer holds at its result step if the
// output register is still full and out_ready is low.
// Reset clears the per-page valid bits at once, so all pages read free;
// no clearing pass is needed.
module contiguous_page_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  logic [cpa_pkg::PID_W-1:0]    process_id,
    input  logic [cpa_pkg::BYTES_W-1:0]  request_bytes,
    input  logic [1:0]                   fit_mode,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [cpa_pkg::IDX_W-1:0]    start_page,
    output logic [cpa_pkg::COUNT_W-1:0]  page_count
);
    import cpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_AINIT, S_SCAN, S_CLOSE, S_WINIT, S_WRITE,
        S_OK, S_FAIL, S_RPRIME, S_RSCAN, S_RDONE
    } step_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_SCAN_INIT, OP_SCAN, OP_CLOSE, OP_WINIT,
        OP_WRITE, OP_RSCAN, OP_RES_ALLOC, OP_RES_FAIL, OP_RES_REL
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT, C_ALWAYS, C_NO_INPUT, C_RELEASE, C_BAD, C_NOT_LAST,
        C_NOT_FOUND, C_MORE_WRITE, C_RSCAN_GO
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  wait_out;
        step_t target;
    } uword_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PAGES - 1);

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        unique case (s)
            S_IDLE:   w = '{OP_LATCH,     C_NO_INPUT,   1'b0, S_IDLE};
            S_DISP:   w = '{OP_NONE,      C_RELEASE,    1'b0, S_RPRIME};
            S_AINIT:  w = '{OP_SCAN_INIT, C_BAD,        1'b0, S_FAIL};
            S_SCAN:   w = '{OP_SCAN,      C_NOT_LAST,   1'b0, S_SCAN};
            S_CLOSE:  w = '{OP_CLOSE,     C_NEXT,       1'b0, S_IDLE};
            S_WINIT:  w = '{OP_WINIT,     C_NOT_FOUND,  1'b0, S_FAIL};
            S_WRITE:  w = '{OP_WRITE,     C_MORE_WRITE, 1'b0, S_WRITE};
            S_OK:     w = '{OP_RES_ALLOC, C_ALWAYS,     1'b1, S_IDLE};
            S_FAIL:   w = '{OP_RES_FAIL,  C_ALWAYS,     1'b1, S_IDLE};
            S_RPRIME: w = '{OP_SCAN_INIT, C_NEXT,       1'b0, S_IDLE};
            S_RSCAN:  w = '{OP_RSCAN,     C_RSCAN_GO,   1'b0, S_RSCAN};
            S_RDONE:  w = '{OP_RES_REL,   C_ALWAYS,     1'b1, S_IDLE};
            default:  w = '{OP_NONE,      C_ALWAYS,     1'b0, S_IDLE};
        endcase
        return w;
    endfunction

    // control
    step_t                step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    logic [NUM_PAGES-1:0] valid_reg, valid_next;

    // datapath
    logic                 kind_reg, kind_next;
    logic [PID_W-1:0]     code_reg, code_next;
    logic                 pid_ok_reg, pid_ok_next;
    logic [1:0]           mode_reg, mode_next;
    logic [PAGES_W-1:0]   pages_reg, pages_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]     run_start_reg, run_start_next;
    logic [COUNT_W-1:0]   run_len_reg, run_len_next;
    logic [IDX_W-1:0]     best_start_reg, best_start_next;
    logic [COUNT_W-1:0]   best_len_reg, best_len_next;
    logic                 found_reg, found_next;
    logic [1:0]           status_reg, status_next;
    logic [IDX_W-1:0]     start_reg, start_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    // owner memory
    logic [PID_W-1:0]     mem [NUM_PAGES];
    logic [PID_W-1:0]     owner_rd_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [PID_W-1:0]     wr_data;

    uword_t               uw;
    logic                 hold, cond_true, load_out;
    logic                 is_free, match, fits, take, bad;
    logic [PAGES_W-1:0]   in_pages;

    assign in_ready   = (step_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign start_page = start_reg;
    assign page_count = count_reg;

    assign in_pages = PAGES_W'(request_bytes[BYTES_W-1:PAGE_SHIFT])
                    + PAGES_W'(|request_bytes[PAGE_SHIFT-1:0]);

    assign is_free = (owner_rd_reg == '0);
    assign match   = pid_ok_reg && (owner_rd_reg == code_reg);
    assign fits    = (PAGES_W'(run_len_reg) >= pages_reg);
    assign bad     = !pid_ok_reg || (mode_reg == FIT_NONE) || (pages_reg == '0)
                   || (pages_reg > PAGES_W'(NUM_PAGES));

    always_comb
    begin
        case (mode_reg)
            FIT_FIRST: take = fits && !found_reg;
            FIT_BEST:  take = fits && (!found_reg || run_len_reg < best_len_reg);
            FIT_WORST: take = fits && (!found_reg || run_len_reg > best_len_reg);
            default:   take = 1'b0;
        endcase
    end

    always_comb
    begin
        uw   = ucode(step_reg);
        hold = uw.wait_out && out_valid_reg && !out_ready;

        unique case (uw.cond)
            C_NEXT:       cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_INPUT:   cond_true = !in_valid;
            C_RELEASE:    cond_true = (kind_reg == KIND_RELEASE);
            C_BAD:        cond_true = bad;
            C_NOT_LAST:   cond_true = (idx_reg != LAST_IDX);
            C_NOT_FOUND:  cond_true = !found_reg;
            C_MORE_WRITE: cond_true = (PAGES_W'(cnt_reg) + PAGES_W'(1)) != pages_reg;
            C_RSCAN_GO:   cond_true = (idx_reg != LAST_IDX) && (!found_reg || match);
            default:      cond_true = 1'b1;
        endcase

        if (hold)
            step_next = step_reg;
        else if (cond_true)
            step_next = uw.target;
        else
            step_next = step_t'(step_reg + 4'd1);

        kind_next       = kind_reg;
        code_next       = code_reg;
        pid_ok_next     = pid_ok_reg;
        mode_next       = mode_reg;
        pages_next      = pages_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_data         = code_reg;
        load_out        = 1'b0;

        unique case (uw.op)
            OP_NONE: ;
            OP_LATCH:
            begin
                if (in_valid)
                begin
                    kind_next   = kind;
                    code_next   = process_id + PID_W'(1);
                    pid_ok_next = (process_id != '1);
                    mode_next   = fit_mode;
                    pages_next  = in_pages;
                end
            end
            OP_SCAN_INIT:
            begin
                rd_addr      = '0;
                idx_next     = '0;
                run_len_next = '0;
                cnt_next     = '0;
                found_next   = 1'b0;
            end
            OP_SCAN:
            begin
                rd_addr  = idx_reg + IDX_W'(1);
                idx_next = idx_reg + IDX_W'(1);
                if (is_free)
                begin
                    if (run_len_reg == '0)
                        run_start_next = idx_reg;
                    run_len_next = run_len_reg + COUNT_W'(1);
                end
                else
                begin
                    run_len_next = '0;
                    if (take)
                    begin
                        best_start_next = run_start_reg;
                        best_len_next   = run_len_reg;
                        found_next      = 1'b1;
                    end
                end
            end
            OP_CLOSE:
            begin
                if (take)
                begin
                    best_start_next = run_start_reg;
                    best_len_next   = run_len_reg;
                    found_next      = 1'b1;
                end
            end
            OP_WINIT:
            begin
                idx_next = best_start_reg;
                cnt_next = '0;
            end
            OP_WRITE:
            begin
                wr_en    = 1'b1;
                wr_data  = code_reg;
                idx_next = idx_reg + IDX_W'(1);
                cnt_next = cnt_reg + COUNT_W'(1);
            end
            OP_RSCAN:
            begin
                rd_addr  = idx_reg + IDX_W'(1);
                idx_next = idx_reg + IDX_W'(1);
                if (match)
                begin
                    wr_en    = 1'b1;
                    wr_data  = '0;
                    cnt_next = cnt_reg + COUNT_W'(1);
                    if (!found_reg)
                    begin
                        best_start_next = idx_reg;
                        found_next      = 1'b1;
                    end
                end
            end
            OP_RES_ALLOC:
            begin
                load_out    = !hold;
                status_next = ST_ALLOC;
                start_next  = best_start_reg;
                count_next  = pages_reg[COUNT_W-1:0];
            end
            OP_RES_FAIL:
            begin
                load_out    = !hold;
                status_next = ST_NOSPACE;
                start_next  = '0;
                count_next  = '0;
            end
            OP_RES_REL:
            begin
                load_out = !hold;
                if (found_reg)
                begin
                    status_next = ST_RELEASED;
                    start_next  = best_start_reg;
                    count_next  = cnt_reg;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                    start_next  = '0;
                    count_next  = '0;
                end
            end
            default: ;
        endcase

        if (!load_out)
        begin
            status_next = status_reg;
            start_next  = start_reg;
            count_next  = count_reg;
        end

        if (wr_en)
            valid_next[idx_reg] = 1'b1;

        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        code_reg       <= code_next;
        pid_ok_reg     <= pid_ok_next;
        mode_reg       <= mode_next;
        pages_reg      <= pages_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        start_reg      <= start_next;
        count_reg      <= count_next;
    end

    // owner memory; entries without a valid bit read as free
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg] <= wr_data;
        owner_rd_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

endmodule

### src/cpa_checker.sv
// Port-level checks for the contiguous page allocator core, bound to it.
// Depends on cpa_pkg.
module cpa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [1:0]                   status,
    input logic [cpa_pkg::IDX_W-1:0]    start_page,
    input logic [cpa_pkg::COUNT_W-1:0]  page_count
);
    import cpa_pkg::*;

    // a word in flight closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a word is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
            && $stable(start_page) && $stable(page_count)))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_NOSPACE || status == ST_NOTFOUND))
            |-> (start_page == '0 && page_count == '0))
        else $error("failed result carries a run");

    a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ALLOC)
            |-> (page_count != '0 && ({1'b0, start_page} + page_count)
                 <= COUNT_W'(NUM_PAGES)))
        else $error("allocated run out of range");

    a_release_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_RELEASED) |-> (page_count != '0))
        else $error("empty release");

endmodule

bind contiguous_page_allocator_core cpa_checker u_cpa_checker (.*);

### tb/page_allocator_checker.sv
// Checker for the contiguous page allocator: tracks page ownership, predicts
// each reply word and compares it with what the core returns.
// Depends on cpa_pkg; instantiated beside the core by the testbench top.
module page_allocator_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          kind,
    input  logic [cpa_pkg::PID_W-1:0]     process_id,
    input  logic [cpa_pkg::BYTES_W-1:0]   request_bytes,
    input  logic [1:0]                    fit_mode,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [1:0]                    status,
    input  logic [cpa_pkg::IDX_W-1:0]     start_page,
    input  logic [cpa_pkg::COUNT_W-1:0]   page_count,
    output int                            faults,
    output int                            outstanding,
    output int                            grants,
    output int                            refusals,
    output int                            frees,
    output int                            misses
);
    import cpa_pkg::*;

    typedef struct packed {
        status_t            st;
        logic [IDX_W-1:0]   start;
        logic [COUNT_W-1:0] count;
    } reply_t;

    logic [PID_W-1:0] owner_map [NUM_PAGES];
    reply_t           awaited_replies [$];

    task automatic place_or_free(
        input  logic               k,
        input  logic [PID_W-1:0]   pid,
        input  logic [BYTES_W-1:0] bytes,
        input  logic [1:0]         mode,
        output reply_t             r
    );
        int   pages;
        int   i;
        int   j;
        int   run_len;
        int   pick;
        int   best_len;
        int   worst_len;
        bit   found;
        logic [PID_W-1:0] code;
        begin
            r.st    = ST_NOSPACE;
            r.start = '0;
            r.count = '0;
            code    = pid + 1'b1;
            if (k == KIND_ALLOC) begin
                pages = int'(bytes >> PAGE_SHIFT)
                      + (((bytes % (1 << PAGE_SHIFT)) != 0) ? 1 : 0);
                if (pid != '1 && fit_t'(mode) != FIT_NONE && pages != 0
                    && pages <= NUM_PAGES) begin
                    found     = 1'b0;
                    best_len  = NUM_PAGES + 1;
                    worst_len = 0;
                    pick      = 0;
                    i         = 0;
                    while (i < NUM_PAGES && !(found && fit_t'(mode) == FIT_FIRST)) begin
                        if (owner_map[i] != '0) begin
                            i++;
                        end
                        else begin
                            j = i;
                            while (j < NUM_PAGES && owner_map[j] == '0)
                                j++;
                            run_len = j - i;
                            if (run_len >= pages) begin
                                case (fit_t'(mode))
                                    FIT_FIRST:
                                    begin
                                        pick  = i;
                                        found = 1'b1;
                                    end
                                    FIT_BEST:
                                    begin
                                        if (run_len < best_len) begin
                                            best_len = run_len;
                                            pick     = i;
                                            found    = 1'b1;
                                        end
                                    end
                                    default:
                                    begin
                                        if (run_len > worst_len) begin
                                            worst_len = run_len;
                                            pick      = i;
                                            found     = 1'b1;
                                        end
                                    end
                                endcase
                            end
                            i = j;
                        end
                    end
                    if (found) begin
                        for (j = pick; j < pick + pages && j < NUM_PAGES; j++)
                            owner_map[j] = code;
                        r.st    = ST_ALLOC;
                        r.start = pick[IDX_W-1:0];
                        r.count = pages[COUNT_W-1:0];
                    end
                end
            end
            else begin
                r.st  = ST_NOTFOUND;
                found = 1'b0;
                if (pid != '1) begin
                    for (i = 0; i < NUM_PAGES && !found; i++) begin
                        if (owner_map[i] == code) begin
                            j = i;
                            while (j < NUM_PAGES && owner_map[j] == code) begin
                                owner_map[j] = '0;
                                j++;
                            end
                            r.st    = ST_RELEASED;
                            r.start = i[IDX_W-1:0];
                            r.count = COUNT_W'(j - i);
                            found   = 1'b1;
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        reply_t want;
        reply_t got;
        if (!rst_n) begin
            for (int p = 0; p < NUM_PAGES; p++)
                owner_map[p] = '0;
            awaited_replies.delete();
            faults      <= 0;
            outstanding <= 0;
            grants      <= 0;
            refusals    <= 0;
            frees       <= 0;
            misses      <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                got.st    = status_t'(status);
                got.start = start_page;
                got.count = page_count;
                if (awaited_replies.size() == 0) begin
                    if (faults < 10)
                        $display("%0t: unexpected reply status=%0d start=%0d count=%0d",
                                 $realtime, status, start_page, page_count);
                    faults <= faults + 1;
                end
                else begin
                    want = awaited_replies.pop_front();
                    if (got.st !== want.st || got.start !== want.start
                        || got.count !== want.count) begin
                        if (faults < 10)
                            $display("%0t: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                                     $realtime, want.st, want.start, want.count,
                                     status, start_page, page_count);
                        faults <= faults + 1;
                    end
                end
            end
            if (in_valid && in_ready) begin
                place_or_free(kind, process_id, request_bytes, fit_mode, want);
                awaited_replies.push_back(want);
                case (want.st)
                    ST_ALLOC:    grants   <= grants + 1;
                    ST_NOSPACE:  refusals <= refusals + 1;
                    ST_RELEASED: frees    <= frees + 1;
                    default:     misses   <= misses + 1;
                endcase
            end
            outstanding <= awaited_replies.size();
        end
    end

endmodule

### tb/contiguous_page_allocator_core_tb.sv
// Testbench top for the contiguous page allocator core: clock, reset,
// directed and random request/release words, random stalls, verdict.
// Depends on cpa_pkg, contiguous_page_allocator_core and page_allocator_checker.
module contiguous_page_allocator_core_tb;
    import cpa_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_WORDS = 1000;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 600;
    localparam int DRAIN_CYCLES = 600;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic               kind          = KIND_ALLOC;
    logic [PID_W-1:0]   process_id    = '0;
    logic [BYTES_W-1:0] request_bytes = '0;
    logic [1:0]         fit_mode      = FIT_FIRST;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic [1:0]         status;
    logic [IDX_W-1:0]   start_page;
    logic [COUNT_W-1:0] page_count;

    int faults;
    int outstanding;
    int grants;
    int refusals;
    int frees;
    int misses;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    always #5 clk = ~clk;

    contiguous_page_allocator_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .process_id    (process_id),
        .request_bytes (request_bytes),
        .fit_mode      (fit_mode),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .start_page    (start_page),
        .page_count    (page_count)
    );

    page_allocator_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .process_id    (process_id),
        .request_bytes (request_bytes),
        .fit_mode      (fit_mode),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .start_page    (start_page),
        .page_count    (page_count),
        .faults        (faults),
        .outstanding   (outstanding),
        .grants        (grants),
        .refusals      (refusals),
        .frees         (frees),
        .misses        (misses)
    );

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 23);

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (rst_n);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic idle_gap();
        begin
            while (!calm && $urandom_range(99) < 23) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_word(
        input logic               k,
        input logic [PID_W-1:0]   pid,
        input logic [BYTES_W-1:0] bytes,
        input logic [1:0]         mode
    );
        begin
            idle_gap();
            in_valid      <= 1'b1;
            kind          <= k;
            process_id    <= pid;
            request_bytes <= bytes;
            fit_mode      <= mode;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    task automatic random_word(
        output logic               k,
        output logic [PID_W-1:0]   pid,
        output logic [BYTES_W-1:0] bytes,
        output logic [1:0]         mode
    );
        int roll;
        int pages;
        begin
            k    = ($urandom_range(99) < 32) ? KIND_RELEASE : KIND_ALLOC;
            roll = $urandom_range(99);
            if (roll < 80)
                pid = PID_W'($urandom_range(11));
            else if (roll < 98)
                pid = PID_W'($urandom_range(254));
            else
                pid = '1;
            roll = $urandom_range(99);
            if (roll < 70)
                pages = $urandom_range(16, 1);
            else if (roll < 90)
                pages = $urandom_range(128, 17);
            else if (roll < 95)
                pages = $urandom_range(NUM_PAGES, 129);
            else
                pages = 0;
            if (pages != 0)
                bytes = BYTES_W'(((pages - 1) << PAGE_SHIFT)
                                 + int'($urandom_range(1 << PAGE_SHIFT, 1)));
            else if (roll < 97)
                bytes = '0;
            else
                bytes = BYTES_W'($urandom_range((1 << BYTES_W) - 1));
            roll = $urandom_range(99);
            if (roll < 3)
                mode = FIT_NONE;
            else
                mode = 2'($urandom_range(FIT_WORST, FIT_FIRST));
        end
    endtask

    initial begin : stimulus
        logic               k;
        logic [PID_W-1:0]   pid;
        logic [BYTES_W-1:0] bytes;
        logic [1:0]         mode;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_RELEASE, 8'd0,   21'd0,       FIT_FIRST);
        send_word(KIND_ALLOC,   8'd0,   21'd0,       FIT_FIRST);
        send_word(KIND_ALLOC,   8'd255, 21'd4096,    FIT_FIRST);
        send_word(KIND_RELEASE, 8'd255, 21'd4096,    FIT_NONE);
        send_word(KIND_ALLOC,   8'd1,   21'd4096,    FIT_NONE);
        send_word(KIND_ALLOC,   8'd1,   21'd1048577, FIT_BEST);
        send_word(KIND_ALLOC,   8'd1,   21'h1FFFFF,  FIT_WORST);
        send_word(KIND_ALLOC,   8'd1,   21'd1048576, FIT_BEST);
        send_word(KIND_ALLOC,   8'd2,   21'd1,       FIT_FIRST);
        send_word(KIND_RELEASE, 8'd1,   21'h1FFFFF,  FIT_BEST);
        send_word(KIND_ALLOC,   8'd0,   21'd1,       FIT_FIRST);
        send_word(KIND_ALLOC,   8'd254, 21'd4097,    FIT_FIRST);
        send_word(KIND_ALLOC,   8'd3,   21'd8192,    FIT_WORST);
        send_word(KIND_ALLOC,   8'd4,   21'd12288,   FIT_FIRST);
        send_word(KIND_ALLOC,   8'd5,   21'd4096,    FIT_FIRST);
        send_word(KIND_RELEASE, 8'd254, 21'd0,       FIT_FIRST);
        send_word(KIND_RELEASE, 8'd4,   21'd0,       FIT_WORST);
        send_word(KIND_ALLOC,   8'd6,   21'd4096,    FIT_BEST);
        send_word(KIND_ALLOC,   8'd7,   21'd4096,    FIT_WORST);
        send_word(KIND_ALLOC,   8'd8,   21'd12288,   FIT_BEST);
        send_word(KIND_RELEASE, 8'd6,   21'd0,       FIT_FIRST);
        send_word(KIND_ALLOC,   8'd3,   21'd4096,    FIT_FIRST);
        send_word(KIND_RELEASE, 8'd3,   21'd0,       FIT_FIRST);
        send_word(KIND_RELEASE, 8'd3,   21'd0,       FIT_FIRST);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm <= (n >= CALM_FROM && n < CALM_TO);
            random_word(k, pid, bytes, mode);
            send_word(k, pid, bytes, mode);
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d grants, %0d refusals, %0d frees, %0d unknown releases",
                 grants, refusals, frees, misses);
        $display("%0d reply mismatches, %0d replies still awaited", faults, outstanding);
        if (faults == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
